// ----- hdl/complex_arith_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Complex arithmetic unit assertion macros
// Shorthand for clocked implication checks, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef COMPLEX_ARITH_UNIT_ASSERT_SVH
`define COMPLEX_ARITH_UNIT_ASSERT_SVH

// Same-cycle implication.
`define CAU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CAU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/cau_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Complex arithmetic unit package
// Widths, opcodes, pipeline types and the saturation function.
// ----------------------------------------------------------------------------
package cau_pkg;

  localparam int DataWidth = 16;
  localparam int FracBits  = 8;
  localparam int AddWidth  = DataWidth + 1;
  localparam int ProdWidth = 2 * DataWidth;
  localparam int SumWidth  = ProdWidth + 1;
  localparam int MagWidth  = ProdWidth;
  localparam int DenWidth  = ProdWidth;
  localparam int QuoWidth  = DataWidth + 1;
  localparam int RemWidth  = MagWidth + FracBits;
  localparam int CmpWidth  = DenWidth + QuoWidth;
  localparam int Half      = 2 ** (DataWidth - 1);

  typedef enum logic [1:0] {
    ActAdd = 2'd0,
    ActSub = 2'd1,
    ActMul = 2'd2,
    ActDiv = 2'd3
  } action_e;

  typedef struct packed {
    logic                valid;
    logic                is_div;
    logic                dz;
    logic                big_re;
    logic                big_im;
    logic                neg_re;
    logic                neg_im;
    logic [DenWidth-1:0] den;
    logic [RemWidth-1:0] r_re;
    logic [RemWidth-1:0] r_im;
    logic [QuoWidth-1:0] q_re;
    logic [QuoWidth-1:0] q_im;
  } step_t;

  typedef struct packed {
    logic signed [DataWidth-1:0] val;
    logic                        ovf;
  } sat_t;

  function automatic sat_t sat(input logic neg, input logic [MagWidth-1:0] mag);
    sat_t                r;
    logic [MagWidth-1:0] lim;
    logic [MagWidth-1:0] m;
    lim   = neg ? MagWidth'(Half) : MagWidth'(Half - 1);
    r.ovf = mag > lim;
    m     = r.ovf ? lim : mag;
    r.val = neg ? DataWidth'(MagWidth'(0) - m) : DataWidth'(m);
    return r;
  endfunction

endpackage

// ----- hdl/cau_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Complex arithmetic unit input channel
// Opcode and two complex operands with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface cau_in_if;
  logic                                 valid;
  logic                                 ready;
  cau_pkg::action_e                     action;
  logic signed [cau_pkg::DataWidth-1:0] a_re;
  logic signed [cau_pkg::DataWidth-1:0] a_im;
  logic signed [cau_pkg::DataWidth-1:0] b_re;
  logic signed [cau_pkg::DataWidth-1:0] b_im;

  modport source (output valid, action, a_re, a_im, b_re, b_im, input ready);
  modport sink   (input valid, action, a_re, a_im, b_re, b_im, output ready);
endinterface

// ----- hdl/cau_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Complex arithmetic unit output channel
// Complex result and status flags with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface cau_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [cau_pkg::DataWidth-1:0] res_re;
  logic signed [cau_pkg::DataWidth-1:0] res_im;
  logic                                 overflow;
  logic                                 div_by_zero;

  modport source (output valid, res_re, res_im, overflow, div_by_zero, input ready);
  modport sink   (input valid, res_re, res_im, overflow, div_by_zero, output ready);
endinterface

// ----- hdl/complex_arith_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Complex arithmetic unit
// Pipelined add, subtract, multiply and divide on signed Q8.8 complex numbers.
// ----------------------------------------------------------------------------
// The unit takes one transfer per cycle while the output is not stalled and
// presents results in order through 21 register stages: one multiplier stage,
// one summing stage, one magnitude stage, seventeen restoring-division
// stages (one quotient bit each, shared path for all opcodes) and the output
// register. When the output is stalled the whole pipeline holds. Results are
// truncated toward zero and saturated; a divide by zero returns zero with
// div_by_zero set.
`include "complex_arith_unit_assert.svh"

module complex_arith_unit (
  input  logic  clk_i,
  input  logic  rst_ni,
  cau_in_if.sink    in_i,
  cau_out_if.source out_o
);

  localparam int Qw = cau_pkg::QuoWidth;

  logic adv;

  // Stage 1: products and part sums.
  logic                                   s1_v_q;
  cau_pkg::action_e                       s1_op_q;
  logic signed [cau_pkg::ProdWidth-1:0]   p_rr_q, p_ii_q, p_ri_q, p_ir_q, p_br_q, p_bi_q;
  logic signed [cau_pkg::AddWidth-1:0]    add_re_d, add_im_d, add_re_q, add_im_q;

  // Stage 2: combined sums and divisor.
  logic                                   s2_v_q;
  cau_pkg::action_e                       s2_op_q;
  logic                                   s2_dz_d, s2_dz_q;
  logic signed [cau_pkg::SumWidth-1:0]    sum_re_d, sum_im_d, sum_re_q, sum_im_q;
  logic [cau_pkg::DenWidth-1:0]           den_d, den_q;

  // Stage 3 onward: magnitudes through the division steps.
  cau_pkg::step_t                         st_d [Qw+1];
  cau_pkg::step_t                         st_q [Qw+1];
  logic [cau_pkg::SumWidth-1:0]           abs_re, abs_im;
  logic [cau_pkg::MagWidth-1:0]           mag_re, mag_im;

  // Output stage.
  logic                                   out_v_q;
  cau_pkg::sat_t                          sat_re, sat_im;
  logic [cau_pkg::MagWidth-1:0]           fin_re, fin_im;
  logic signed [cau_pkg::DataWidth-1:0]   res_re_q, res_im_q;
  logic                                   ovf_q, dz_q;

  assign adv        = !out_v_q || out_o.ready;
  assign in_i.ready = adv;

  always_comb begin
    unique case (in_i.action)
      cau_pkg::ActSub: begin
        add_re_d = cau_pkg::AddWidth'(in_i.a_re) - cau_pkg::AddWidth'(in_i.b_re);
        add_im_d = cau_pkg::AddWidth'(in_i.a_im) - cau_pkg::AddWidth'(in_i.b_im);
      end
      cau_pkg::ActAdd, cau_pkg::ActMul, cau_pkg::ActDiv: begin
        add_re_d = cau_pkg::AddWidth'(in_i.a_re) + cau_pkg::AddWidth'(in_i.b_re);
        add_im_d = cau_pkg::AddWidth'(in_i.a_im) + cau_pkg::AddWidth'(in_i.b_im);
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_op_q  <= in_i.action;
      p_rr_q   <= cau_pkg::ProdWidth'(in_i.a_re) * cau_pkg::ProdWidth'(in_i.b_re);
      p_ii_q   <= cau_pkg::ProdWidth'(in_i.a_im) * cau_pkg::ProdWidth'(in_i.b_im);
      p_ri_q   <= cau_pkg::ProdWidth'(in_i.a_re) * cau_pkg::ProdWidth'(in_i.b_im);
      p_ir_q   <= cau_pkg::ProdWidth'(in_i.a_im) * cau_pkg::ProdWidth'(in_i.b_re);
      p_br_q   <= cau_pkg::ProdWidth'(in_i.b_re) * cau_pkg::ProdWidth'(in_i.b_re);
      p_bi_q   <= cau_pkg::ProdWidth'(in_i.b_im) * cau_pkg::ProdWidth'(in_i.b_im);
      add_re_q <= add_re_d;
      add_im_q <= add_im_d;
    end
  end

  always_comb begin
    den_d   = cau_pkg::DenWidth'(p_br_q) + cau_pkg::DenWidth'(p_bi_q);
    s2_dz_d = 1'b0;
    unique case (s1_op_q)
      cau_pkg::ActMul: begin
        sum_re_d = cau_pkg::SumWidth'(p_rr_q) - cau_pkg::SumWidth'(p_ii_q);
        sum_im_d = cau_pkg::SumWidth'(p_ri_q) + cau_pkg::SumWidth'(p_ir_q);
      end
      cau_pkg::ActDiv: begin
        s2_dz_d  = den_d == '0;
        sum_re_d = cau_pkg::SumWidth'(p_rr_q) + cau_pkg::SumWidth'(p_ii_q);
        sum_im_d = cau_pkg::SumWidth'(p_ir_q) - cau_pkg::SumWidth'(p_ri_q);
        if (s2_dz_d) begin
          sum_re_d = '0;
          sum_im_d = '0;
        end
      end
      cau_pkg::ActAdd, cau_pkg::ActSub: begin
        sum_re_d = cau_pkg::SumWidth'(add_re_q);
        sum_im_d = cau_pkg::SumWidth'(add_im_q);
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_op_q  <= s1_op_q;
      s2_dz_q  <= s2_dz_d;
      sum_re_q <= sum_re_d;
      sum_im_q <= sum_im_d;
      den_q    <= den_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q <= in_i.valid;
      s2_v_q <= s1_v_q;
    end
  end

  always_comb begin
    abs_re = sum_re_q[cau_pkg::SumWidth-1] ? cau_pkg::SumWidth'(-sum_re_q)
                                           : cau_pkg::SumWidth'(sum_re_q);
    abs_im = sum_im_q[cau_pkg::SumWidth-1] ? cau_pkg::SumWidth'(-sum_im_q)
                                           : cau_pkg::SumWidth'(sum_im_q);
    mag_re = abs_re[cau_pkg::MagWidth-1:0];
    mag_im = abs_im[cau_pkg::MagWidth-1:0];
    if (s2_op_q == cau_pkg::ActMul) begin
      mag_re = mag_re >> cau_pkg::FracBits;
      mag_im = mag_im >> cau_pkg::FracBits;
    end
    st_d[0]        = '0;
    st_d[0].valid  = s2_v_q;
    st_d[0].is_div = (s2_op_q == cau_pkg::ActDiv) && !s2_dz_q;
    st_d[0].dz     = s2_dz_q;
    st_d[0].neg_re = sum_re_q[cau_pkg::SumWidth-1];
    st_d[0].neg_im = sum_im_q[cau_pkg::SumWidth-1];
    st_d[0].den    = den_q;
    if (st_d[0].is_div) begin
      st_d[0].r_re = {mag_re, cau_pkg::FracBits'(0)};
      st_d[0].r_im = {mag_im, cau_pkg::FracBits'(0)};
    end else begin
      st_d[0].r_re = cau_pkg::RemWidth'(mag_re);
      st_d[0].r_im = cau_pkg::RemWidth'(mag_im);
    end
  end

  for (genvar k = 0; k < Qw; k++) begin : g_step
    localparam int Bit = Qw - 1 - k;
    logic [cau_pkg::CmpWidth-1:0] dd;
    logic [cau_pkg::CmpWidth-1:0] rr_re, rr_im;

    always_comb begin
      dd           = cau_pkg::CmpWidth'(st_q[k].den) << Bit;
      rr_re        = cau_pkg::CmpWidth'(st_q[k].r_re);
      rr_im        = cau_pkg::CmpWidth'(st_q[k].r_im);
      st_d[k+1]    = st_q[k];
      if (k == 0) begin
        st_d[k+1].big_re = st_q[k].is_div && (rr_re >= (dd << 1));
        st_d[k+1].big_im = st_q[k].is_div && (rr_im >= (dd << 1));
      end
      if (st_q[k].is_div && rr_re >= dd) begin
        st_d[k+1].r_re      = cau_pkg::RemWidth'(rr_re - dd);
        st_d[k+1].q_re[Bit] = 1'b1;
      end
      if (st_q[k].is_div && rr_im >= dd) begin
        st_d[k+1].r_im      = cau_pkg::RemWidth'(rr_im - dd);
        st_d[k+1].q_im[Bit] = 1'b1;
      end
    end
  end

  for (genvar k = 0; k <= Qw; k++) begin : g_stage
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        st_q[k] <= '0;
      end else if (adv) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  always_comb begin
    if (!st_q[Qw].is_div) begin
      fin_re = st_q[Qw].r_re[cau_pkg::MagWidth-1:0];
      fin_im = st_q[Qw].r_im[cau_pkg::MagWidth-1:0];
    end else begin
      fin_re = st_q[Qw].big_re ? cau_pkg::MagWidth'(cau_pkg::Half + 1)
                               : cau_pkg::MagWidth'(st_q[Qw].q_re);
      fin_im = st_q[Qw].big_im ? cau_pkg::MagWidth'(cau_pkg::Half + 1)
                               : cau_pkg::MagWidth'(st_q[Qw].q_im);
    end
    sat_re = cau_pkg::sat(st_q[Qw].neg_re, fin_re);
    sat_im = cau_pkg::sat(st_q[Qw].neg_im, fin_im);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= st_q[Qw].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_re_q <= sat_re.val;
      res_im_q <= sat_im.val;
      ovf_q    <= sat_re.ovf || sat_im.ovf;
      dz_q     <= st_q[Qw].dz;
    end
  end

  assign out_o.valid       = out_v_q;
  assign out_o.res_re      = res_re_q;
  assign out_o.res_im      = res_im_q;
  assign out_o.overflow    = ovf_q;
  assign out_o.div_by_zero = dz_q;

  `CAU_ASSERT_IMP(a_dz_no_ovf, out_v_q && dz_q, !ovf_q,
    "Divide by zero reported together with overflow.")
  `CAU_ASSERT_IMP(a_dz_zero, out_v_q && dz_q, res_re_q == '0 && res_im_q == '0,
    "Divide by zero returned a nonzero result.")
  `CAU_ASSERT_IMP(a_ovf_limit, out_v_q && ovf_q,
    res_re_q == cau_pkg::DataWidth'(cau_pkg::Half) ||
    res_re_q == cau_pkg::DataWidth'(cau_pkg::Half - 1) ||
    res_im_q == cau_pkg::DataWidth'(cau_pkg::Half) ||
    res_im_q == cau_pkg::DataWidth'(cau_pkg::Half - 1),
    "Overflow flagged without a saturated part.")
  `CAU_ASSERT_NEXT(a_last_to_out, st_q[Qw].valid && adv, out_v_q,
    "Result in the last division stage was lost.")

endmodule
